@@ hdl/wsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the work-stealing deque set.
// No dependencies; used by every other file of the block except wsd_ram.
package wsd_pkg;

    localparam int MAX_LISTS   = 8;
    localparam int QUEUE_DEPTH = 64;

    localparam int STORE_DEPTH = MAX_LISTS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LIST_W      = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int LNUM_W      = $clog2(MAX_LISTS + 1);

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int LIDX_W   = 3;
    localparam int BASE_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int REGION_W = 64;
    localparam int LCOUNT_W = 7;
    localparam int CUR_W    = 3;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_DIST  = 2'd1,
        REQ_GET   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef struct packed {
        logic [BASE_W-1:0]   base;
        logic [SIZE_W-1:0]   size;
        logic [REGION_W-1:0] region;
        logic                comp;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    // queue table operations
    typedef enum logic [2:0] {
        Q_NONE,
        Q_PUSH,
        Q_POP_BACK,
        Q_POP_FRONT,
        Q_CLEAR
    } t_qop;

    typedef struct packed {
        t_qop              op;
        logic [LIST_W-1:0] idx;
    } t_qcmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [SLOT_W-1:0] front;
        logic [SLOT_W-1:0] tail_slot;   // first free slot
        logic [SLOT_W-1:0] last_slot;   // newest item
        logic              all_empty;
    } t_qstat;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] s);
        logic [SLOT_W:0] r;
        r = (s >= (SLOT_W+1)'(QUEUE_DEPTH)) ? s - (SLOT_W+1)'(QUEUE_DEPTH) : s;
        return r[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIST_W-1:0] q,
                                                     input logic [SLOT_W-1:0] s);
        return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(s);
    endfunction

endpackage

@@ hdl/wsd_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready) of the deque set.
// Depends on wsd_pkg for field widths.
interface wsd_req_if;
    logic                           valid;
    logic                           ready;
    logic [wsd_pkg::REQ_W-1:0]      req_type;
    logic [wsd_pkg::LIDX_W-1:0]     list_index;
    logic                           batch_start;
    logic [wsd_pkg::BASE_W-1:0]     page_base;
    logic [wsd_pkg::SIZE_W-1:0]     page_size;
    logic [wsd_pkg::REGION_W-1:0]   region_id;
    logic                           needs_compaction;

    modport source (output valid, req_type, list_index, batch_start, page_base,
                    page_size, region_id, needs_compaction, input ready);
    modport sink   (input valid, req_type, list_index, batch_start, page_base,
                    page_size, region_id, needs_compaction, output ready);
endinterface

interface wsd_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic                           was_stolen;
    logic [wsd_pkg::LIDX_W-1:0]     source_list;
    logic [wsd_pkg::BASE_W-1:0]     out_page_base;
    logic [wsd_pkg::SIZE_W-1:0]     out_page_size;
    logic [wsd_pkg::REGION_W-1:0]   out_region_id;
    logic                           out_compaction;
    logic                           push_dropped;
    logic                           all_empty;
    logic [wsd_pkg::LCOUNT_W-1:0]   list_count;

    modport source (output valid, found, was_stolen, source_list, out_page_base,
                    out_page_size, out_region_id, out_compaction, push_dropped,
                    all_empty, list_count, input ready);
    modport sink   (input valid, found, was_stolen, source_list, out_page_base,
                    out_page_size, out_region_id, out_compaction, push_dropped,
                    all_empty, list_count, output ready);
endinterface

@@ hdl/wsd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/wsd_qtab.sv @@
`timescale 1ns / 1ps
// Per-queue front pointer and fill count, one indexed read and update a cycle.
// Depends on wsd_pkg.
module wsd_qtab (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wsd_pkg::t_qcmd              i_cmd,
    input  logic [wsd_pkg::LNUM_W-1:0]  i_live,
    output wsd_pkg::t_qstat             o_stat
);

    logic [wsd_pkg::FILL_W-1:0] r_fill  [wsd_pkg::MAX_LISTS];
    logic [wsd_pkg::SLOT_W-1:0] r_front [wsd_pkg::MAX_LISTS];

    logic                        w_idx_ok;
    logic [wsd_pkg::FILL_W-1:0]  w_fill;
    logic [wsd_pkg::SLOT_W-1:0]  w_front;
    logic [wsd_pkg::SLOT_W:0]    w_sum;
    logic                        w_empty;

    assign w_idx_ok = int'(i_cmd.idx) < wsd_pkg::MAX_LISTS;
    assign w_fill   = w_idx_ok ? r_fill[i_cmd.idx]  : '0;
    assign w_front  = w_idx_ok ? r_front[i_cmd.idx] : '0;
    assign w_sum    = (wsd_pkg::SLOT_W+1)'(w_front) + (wsd_pkg::SLOT_W+1)'(w_fill);

    always_comb begin
        w_empty = 1'b1;
        for (int k = 0; k < wsd_pkg::MAX_LISTS; k++) begin
            if (k < int'(i_live) && r_fill[k] != '0) begin
                w_empty = 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.fill      = w_fill;
        o_stat.front     = w_front;
        o_stat.tail_slot = wsd_pkg::wrap_slot(w_sum);
        o_stat.last_slot = wsd_pkg::wrap_slot(w_sum - 1'b1);
        o_stat.all_empty = w_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wsd_pkg::MAX_LISTS; k++) begin
                r_fill[k]  <= '0;
                r_front[k] <= '0;
            end
        end else if (w_idx_ok) begin
            unique case (i_cmd.op)
                wsd_pkg::Q_PUSH: begin
                    r_fill[i_cmd.idx] <= w_fill + 1'b1;
                end
                wsd_pkg::Q_POP_BACK: begin
                    r_fill[i_cmd.idx] <= w_fill - 1'b1;
                end
                wsd_pkg::Q_POP_FRONT: begin
                    r_fill[i_cmd.idx]  <= w_fill - 1'b1;
                    r_front[i_cmd.idx] <= wsd_pkg::wrap_slot((wsd_pkg::SLOT_W+1)'(w_front) + 1'b1);
                end
                wsd_pkg::Q_CLEAR: begin
                    r_fill[i_cmd.idx]  <= '0;
                    r_front[i_cmd.idx] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/wsd_seq.sv @@
`timescale 1ns / 1ps
// Request sequencer: plans each request, drives the queue table and the item
// RAM one step a cycle, scans for a victim, holds the response register.
// Depends on wsd_pkg and wsd_if.
module wsd_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wsd_pkg::CFG_W-1:0]     i_active,
    wsd_req_if.sink                       i_req,
    wsd_rsp_if.source                     o_rsp,
    output wsd_pkg::t_qcmd                o_qcmd,
    input  wsd_pkg::t_qstat               i_qstat,
    output logic                          o_ram_we,
    output logic                          o_ram_re,
    output logic [wsd_pkg::ADDR_W-1:0]    o_ram_addr,
    output wsd_pkg::t_item                o_ram_wdata,
    input  wsd_pkg::t_item                i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_CHK,
        S_SRCH,
        S_RD,
        S_FIN
    } t_state;

    t_state                       r_state;
    wsd_pkg::t_req                r_req;
    logic [wsd_pkg::LIDX_W-1:0]   r_li;
    logic                         r_batch;
    wsd_pkg::t_item               r_item;
    logic [wsd_pkg::LIST_W-1:0]   r_q;
    logic [wsd_pkg::LNUM_W-1:0]   r_k;
    logic [wsd_pkg::CUR_W-1:0]    r_cursor;
    logic                         r_found;
    logic                         r_stolen;
    logic [wsd_pkg::LIST_W-1:0]   r_src;
    logic                         r_drop;

    logic                         r_ov;
    logic                         r_o_found;
    logic                         r_o_stolen;
    logic [wsd_pkg::LIDX_W-1:0]   r_o_src;
    wsd_pkg::t_item               r_o_item;
    logic                         r_o_drop;
    logic                         r_o_empty;
    logic [wsd_pkg::LCOUNT_W-1:0] r_o_count;

    logic [wsd_pkg::LNUM_W-1:0]   w_live;
    logic [wsd_pkg::LIST_W-1:0]   w_li;
    logic                         w_li_live;
    logic                         w_li_ok;
    logic                         w_full;
    logic                         w_has;
    logic                         w_is_add;
    logic [wsd_pkg::CUR_W-1:0]    w_cur;
    logic [wsd_pkg::LIST_W-1:0]   w_dq;
    logic [wsd_pkg::LNUM_W:0]     w_dq1;
    logic [wsd_pkg::LNUM_W:0]     w_q1;
    logic [wsd_pkg::LIST_W-1:0]   w_qnext;
    logic                         w_scan_end;
    logic                         w_out_free;

    // active count clamped to 1..MAX_LISTS
    always_comb begin
        priority if (i_active == '0) begin
            w_live = wsd_pkg::LNUM_W'(1);
        end else if (int'(i_active) > wsd_pkg::MAX_LISTS) begin
            w_live = wsd_pkg::LNUM_W'(wsd_pkg::MAX_LISTS);
        end else begin
            w_live = wsd_pkg::LNUM_W'(i_active);
        end
    end

    assign w_li       = wsd_pkg::LIST_W'(r_li);
    assign w_li_live  = int'(r_li) < int'(w_live);
    assign w_li_ok    = int'(r_li) < wsd_pkg::MAX_LISTS;
    assign w_full     = int'(i_qstat.fill) >= wsd_pkg::QUEUE_DEPTH;
    assign w_has      = i_qstat.fill != '0;
    assign w_is_add   = (r_req == wsd_pkg::REQ_PUSH) || (r_req == wsd_pkg::REQ_DIST);

    // round-robin target and next cursor
    assign w_cur   = r_batch ? '0 : r_cursor;
    assign w_dq    = (int'(w_cur) >= int'(w_live)) ? '0 : wsd_pkg::LIST_W'(w_cur);
    assign w_dq1   = (wsd_pkg::LNUM_W+1)'(w_dq) + 1'b1;

    // victim scan step, upward with wraparound
    assign w_q1       = (wsd_pkg::LNUM_W+1)'(r_q) + 1'b1;
    assign w_qnext    = (w_q1 >= (wsd_pkg::LNUM_W+1)'(w_live)) ? '0 : wsd_pkg::LIST_W'(w_q1);
    assign w_scan_end = ((wsd_pkg::LNUM_W+1)'(r_k) + 1'b1) >= (wsd_pkg::LNUM_W+1)'(w_live);

    assign w_out_free = !r_ov || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_ram_wdata = r_item;

    always_comb begin
        o_qcmd.op  = wsd_pkg::Q_NONE;
        o_qcmd.idx = r_q;
        o_ram_we   = 1'b0;
        o_ram_re   = 1'b0;
        o_ram_addr = wsd_pkg::slot_addr(r_q, i_qstat.tail_slot);
        unique case (r_state)
            S_PLAN: begin
                if (r_req == wsd_pkg::REQ_CLEAR && w_li_live) begin
                    o_qcmd.op  = wsd_pkg::Q_CLEAR;
                    o_qcmd.idx = w_li;
                end
            end
            S_CHK: begin
                if (w_is_add) begin
                    if (!w_full) begin
                        o_ram_we  = 1'b1;
                        o_qcmd.op = wsd_pkg::Q_PUSH;
                    end
                end else if (w_has) begin
                    o_ram_re   = 1'b1;
                    o_ram_addr = wsd_pkg::slot_addr(r_q, i_qstat.last_slot);
                    o_qcmd.op  = wsd_pkg::Q_POP_BACK;
                end
            end
            S_SRCH: begin
                if (w_has) begin
                    o_ram_re   = 1'b1;
                    o_ram_addr = wsd_pkg::slot_addr(r_q, i_qstat.front);
                    o_qcmd.op  = wsd_pkg::Q_POP_FRONT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_q      <= '0;
            r_cursor <= '0;
            r_ov     <= 1'b0;
        end else begin
            // S_FIN reloads the output register itself
            if (o_rsp.valid && o_rsp.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req         <= wsd_pkg::t_req'(i_req.req_type);
                        r_li          <= i_req.list_index;
                        r_batch       <= i_req.batch_start;
                        r_item.base   <= i_req.page_base;
                        r_item.size   <= i_req.page_size;
                        r_item.region <= i_req.region_id;
                        r_item.comp   <= i_req.needs_compaction;
                        r_found       <= 1'b0;
                        r_stolen      <= 1'b0;
                        r_src         <= '0;
                        r_drop        <= 1'b0;
                        r_state       <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_q <= w_li;
                    unique case (r_req)
                        wsd_pkg::REQ_PUSH: begin
                            if (w_li_live) begin
                                r_state <= S_CHK;
                            end else begin
                                r_drop  <= 1'b1;
                                r_state <= S_FIN;
                            end
                        end
                        wsd_pkg::REQ_DIST: begin
                            r_q      <= w_dq;
                            r_cursor <= (w_dq1 >= (wsd_pkg::LNUM_W+1)'(w_live)) ?
                                        '0 : wsd_pkg::CUR_W'(w_dq1);
                            r_state  <= S_CHK;
                        end
                        wsd_pkg::REQ_GET: begin
                            r_state <= w_li_live ? S_CHK : S_FIN;
                        end
                        wsd_pkg::REQ_CLEAR: begin
                            r_state <= S_FIN;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_CHK: begin
                    if (w_is_add) begin
                        r_drop  <= w_full;
                        r_q     <= w_li;
                        r_state <= S_FIN;
                    end else if (w_has) begin
                        r_found <= 1'b1;
                        r_src   <= r_q;
                        r_state <= S_RD;
                    end else if (int'(w_live) <= 1) begin
                        r_q     <= w_li;
                        r_state <= S_FIN;
                    end else begin
                        r_q     <= w_qnext;
                        r_k     <= wsd_pkg::LNUM_W'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_has) begin
                        r_found  <= 1'b1;
                        r_stolen <= 1'b1;
                        r_src    <= r_q;
                        r_state  <= S_RD;
                    end else if (w_scan_end) begin
                        r_q     <= w_li;
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_q <= w_qnext;
                    end
                end
                S_RD: begin
                    r_item  <= i_ram_rdata;
                    r_q     <= w_li;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ov       <= 1'b1;
                        r_o_found  <= r_found;
                        r_o_stolen <= r_stolen;
                        r_o_src    <= wsd_pkg::LIDX_W'(r_src);
                        r_o_item   <= r_found ? r_item : '0;
                        r_o_drop   <= r_drop;
                        r_o_empty  <= i_qstat.all_empty;
                        r_o_count  <= w_li_ok ? wsd_pkg::LCOUNT_W'(i_qstat.fill) : '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.found          = r_o_found;
    assign o_rsp.was_stolen     = r_o_stolen;
    assign o_rsp.source_list    = r_o_src;
    assign o_rsp.out_page_base  = r_o_item.base;
    assign o_rsp.out_page_size  = r_o_item.size;
    assign o_rsp.out_region_id  = r_o_item.region;
    assign o_rsp.out_compaction = r_o_item.comp;
    assign o_rsp.push_dropped   = r_o_drop;
    assign o_rsp.all_empty      = r_o_empty;
    assign o_rsp.list_count     = r_o_count;

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_re |=> r_state == S_RD)
        else $error("RAM read not followed by capture");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (!w_full && r_state == S_CHK))
        else $error("item written into a full queue");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(i_qstat.fill) <= wsd_pkg::QUEUE_DEPTH)
        else $error("queue fill above depth");

    a_stolen_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.was_stolen) |-> o_rsp.found)
        else $error("steal flagged without an item");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |->
            (o_rsp.out_page_base == '0 && o_rsp.out_region_id == '0
             && o_rsp.source_list == '0))
        else $error("empty response carries item data");

endmodule

@@ hdl/work_stealing_deque_set_unit.sv @@
`timescale 1ns / 1ps
// Top level of the work-stealing deque set: config register and instances.
// Depends on wsd_pkg, wsd_if, wsd_ram, wsd_qtab, wsd_seq.
//
// One bounded deque of work items per worker (up to 8 workers, 64 items
// each); items live in a single registered-read RAM, front pointers and fill
// counts in flops. One request is in flight at a time and every request
// yields exactly one response beat. A push to an inactive queue, a clear, or a
// get from an inactive worker goes from planning straight to the final step;
// push and distribute first check the fill count and write the RAM; a get
// served from the worker's own queue also waits on the RAM's registered read;
// a steal first steps the victim scan one fill count per cycle, then reads the
// RAM; a get that finds all active queues empty ends after the scan. The
// response register lets the next request be taken while a result waits; the
// block only holds in its final step if the previous result has not yet been
// taken. active_lists may be written only while no request is in flight;
// 0 acts as 1, above 8 acts as 8. No clearing pass after reset: only occupied
// slots are ever read.
module work_stealing_deque_set_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wsd_pkg::CFG_W-1:0] i_cfg_wdata,
    wsd_req_if.sink                   i_req,
    wsd_rsp_if.source                 o_rsp
);

    logic [wsd_pkg::CFG_W-1:0]  r_active;

    wsd_pkg::t_qcmd             w_qcmd;
    wsd_pkg::t_qstat            w_qstat;
    logic                       w_ram_we;
    logic                       w_ram_re;
    logic [wsd_pkg::ADDR_W-1:0] w_ram_addr;
    wsd_pkg::t_item             w_ram_wdata;
    wsd_pkg::t_item             w_ram_rdata;
    logic [wsd_pkg::LNUM_W-1:0] w_live;

    // active queue count; reset to all queues in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= wsd_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // clamped count for the all-empty reduction in the queue table
    always_comb begin
        priority if (r_active == '0) begin
            w_live = wsd_pkg::LNUM_W'(1);
        end else if (int'(r_active) > wsd_pkg::MAX_LISTS) begin
            w_live = wsd_pkg::LNUM_W'(wsd_pkg::MAX_LISTS);
        end else begin
            w_live = wsd_pkg::LNUM_W'(r_active);
        end
    end

    wsd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (r_active),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_qcmd      (w_qcmd),
        .i_qstat     (w_qstat),
        .o_ram_we    (w_ram_we),
        .o_ram_re    (w_ram_re),
        .o_ram_addr  (w_ram_addr),
        .o_ram_wdata (w_ram_wdata),
        .i_ram_rdata (w_ram_rdata)
    );

    wsd_qtab u_qtab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_qcmd),
        .i_live  (w_live),
        .o_stat  (w_qstat)
    );

    // item store: base, size, region and compaction flag side by side
    wsd_ram #(
        .WIDTH (wsd_pkg::ITEM_W),
        .DEPTH (wsd_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_addr),
        .o_rdata (w_ram_rdata)
    );

endmodule
